>>> hw/rtl/aslt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aslt_pkg: shared types and codes for the active semaphore list table
// commands, status codes and the transaction structs
// ----------------------------------------------------------------------------
package aslt_pkg;

    localparam int unsigned MAX_PROCS_DEF = 32;
    localparam int unsigned KEY_BITS_DEF  = 32;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned SKEY_W        = 32;
    localparam int unsigned PID_W         = 5;
    localparam int unsigned STAT_W        = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OUT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HEAD   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SKEY_W-1:0] sem_key;
        logic [PID_W-1:0]  proc_id;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  result_proc;
    } t_res;

endpackage

>>> hw/rtl/semaphore_wait_queue_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table_core: active semaphore list
// keyed descriptor table with a blocked-pid fifo per descriptor
// ----------------------------------------------------------------------------
// One command transaction is taken when i_start is high and o_busy is low; the
// result appears on o_res for one cycle with o_done high and cannot be stalled.
// Each command walks the descriptor table one entry per cycle with a single
// key comparator (and, for an insert, tracks the lowest free slot on the same
// pass), then goes through the load and update states to the result. No
// clearing pass after reset is needed: descriptor and pid valid bits are
// flip-flops cleared by reset.
module semaphore_wait_queue_table_core #(
    parameter int unsigned MAX_PROCS = aslt_pkg::MAX_PROCS_DEF,
    parameter int unsigned KEY_BITS  = aslt_pkg::KEY_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  aslt_pkg::t_cmd i_cmd,
    output logic           o_busy,
    output logic           o_done,
    output aslt_pkg::t_res o_res
);
    localparam int unsigned IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned CW = $clog2(MAX_PROCS + 1);
    localparam int unsigned KW = (KEY_BITS < aslt_pkg::SKEY_W) ? KEY_BITS : aslt_pkg::SKEY_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LOAD = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // per-entry storage
    logic [MAX_PROCS-1:0] r_dact;
    logic [MAX_PROCS-1:0] r_pwait;
    logic [KW-1:0] r_dkey [MAX_PROCS];
    logic [IW-1:0] r_dhead [MAX_PROCS];
    logic [IW-1:0] r_dtail [MAX_PROCS];
    logic [IW-1:0] r_pnext [MAX_PROCS];
    logic [IW-1:0] r_pprev [MAX_PROCS];
    logic [KW-1:0] r_pkey [MAX_PROCS];

    // transaction context
    logic [aslt_pkg::CMD_W-1:0] r_cmd;
    logic [KW-1:0] r_key;
    logic [IW-1:0] r_pid;
    logic          r_pid_ok;
    logic [CW-1:0] r_cnt;
    logic          r_hit, r_free_ok;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic [IW-1:0] r_head, r_tail, r_nx, r_pv;
    aslt_pkg::t_res r_res;

    logic [IW-1:0] w_idx;
    logic          w_match;

    assign w_idx   = r_cnt[IW-1:0];
    // the shared key comparator
    assign w_match = r_dact[w_idx] && (r_dkey[w_idx] == r_key);

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_SCAN;
            S_SCAN: if (r_cnt == CW'(MAX_PROCS - 1)) n_state = S_LOAD;
            S_LOAD: n_state = S_UPD;
            S_UPD:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dact  <= '0;
            r_pwait <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd     <= i_cmd.command;
                        r_pid     <= IW'(i_cmd.proc_id);
                        r_pid_ok  <= (32'(i_cmd.proc_id) < MAX_PROCS);
                        r_cnt     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        if (i_cmd.command == aslt_pkg::CMD_OUT)
                            r_key <= r_pkey[IW'(i_cmd.proc_id)];
                        else
                            r_key <= i_cmd.sem_key[KW-1:0];
                    end
                end
                S_SCAN: begin
                    if (w_match && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= w_idx;
                    end
                    if (!r_dact[w_idx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= w_idx;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_LOAD: begin
                    // fetch descriptor and link pointers
                    r_head <= r_dhead[r_hit_idx];
                    r_tail <= r_dtail[r_hit_idx];
                    if (r_cmd == aslt_pkg::CMD_OUT) begin
                        r_nx <= r_pnext[r_pid];
                        r_pv <= r_pprev[r_pid];
                    end else begin
                        r_nx <= r_pnext[r_dhead[r_hit_idx]];
                        r_pv <= r_pprev[r_dhead[r_hit_idx]];
                    end
                end
                S_UPD: begin
                    case (r_cmd)
                        aslt_pkg::CMD_INSERT: begin
                            if (r_pid_ok && !r_pwait[r_pid]) begin
                                if (r_hit) begin
                                    r_pnext[r_tail] <= r_pid;
                                    r_pprev[r_pid]  <= r_tail;
                                    r_pnext[r_pid]  <= r_pid;
                                    r_dtail[r_hit_idx] <= r_pid;
                                    r_pwait[r_pid] <= 1'b1;
                                    r_pkey[r_pid]  <= r_key;
                                    r_res <= '{status: aslt_pkg::ST_OK, result_proc: '0};
                                end else if (r_free_ok) begin
                                    r_dact[r_free_idx]  <= 1'b1;
                                    r_dkey[r_free_idx]  <= r_key;
                                    r_dhead[r_free_idx] <= r_pid;
                                    r_dtail[r_free_idx] <= r_pid;
                                    r_pprev[r_pid] <= r_pid;
                                    r_pnext[r_pid] <= r_pid;
                                    r_pwait[r_pid] <= 1'b1;
                                    r_pkey[r_pid]  <= r_key;
                                    r_res <= '{status: aslt_pkg::ST_OK, result_proc: '0};
                                end else begin
                                    r_res <= '{status: aslt_pkg::ST_NOFREE, result_proc: '0};
                                end
                            end else begin
                                r_res <= '{status: aslt_pkg::ST_NOTFOUND, result_proc: '0};
                            end
                        end
                        aslt_pkg::CMD_HEAD: begin
                            if (r_hit)
                                r_res <= '{status: aslt_pkg::ST_OK,
                                           result_proc: aslt_pkg::PID_W'(r_head)};
                            else
                                r_res <= '{status: aslt_pkg::ST_NOTFOUND, result_proc: '0};
                        end
                        default: begin
                            // remove pops the head, out unlinks a given pid
                            if (r_hit && (r_cmd == aslt_pkg::CMD_REMOVE ||
                                          (r_pid_ok && r_pwait[r_pid]))) begin
                                logic [IW-1:0] p;
                                p = (r_cmd == aslt_pkg::CMD_REMOVE) ? r_head : r_pid;
                                if (r_head == p && r_tail == p) begin
                                    r_dact[r_hit_idx] <= 1'b0;
                                end else if (r_head == p) begin
                                    r_dhead[r_hit_idx] <= r_nx;
                                end else if (r_tail == p) begin
                                    r_dtail[r_hit_idx] <= r_pv;
                                end else begin
                                    r_pnext[r_pv] <= r_nx;
                                    r_pprev[r_nx] <= r_pv;
                                end
                                r_pwait[p] <= 1'b0;
                                r_res <= '{status: aslt_pkg::ST_OK,
                                           result_proc: aslt_pkg::PID_W'(p)};
                            end else begin
                                r_res <= '{status: aslt_pkg::ST_NOTFOUND, result_proc: '0};
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_UPD)) else $error("done without update");
    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_ok_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != aslt_pkg::ST_OK) |-> o_res.result_proc == '0)
        else $error("nonzero pid with error");
`endif
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the active semaphore list table
// drives insert/remove/out/head command transactions, predicts each status
// and pid with a behavioral copy of the descriptor table and pid queues
// ----------------------------------------------------------------------------
module testbench;

    localparam int NPROC = 32;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    aslt_pkg::t_cmd i_cmd;
    logic o_busy;
    logic o_done;
    aslt_pkg::t_res o_res;

    semaphore_wait_queue_table_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_cmd  (i_cmd),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // shadow of the table: descriptors and per-pid links
    logic        sh_active [NPROC];
    logic [31:0] sh_key    [NPROC];
    logic [4:0]  sh_head   [NPROC];
    logic [4:0]  sh_tail   [NPROC];
    logic [4:0]  sh_next   [NPROC];
    logic [4:0]  sh_prev   [NPROC];
    logic        sh_wait   [NPROC];
    logic [31:0] sh_wkey   [NPROC];

    aslt_pkg::t_cmd pending_cmds[$];
    aslt_pkg::t_res expected_res[$];
    int   error_count = 0;
    int   accepted_count = 0;
    int   checked_count = 0;
    int   ok_count = 0;
    int   nofree_count = 0;
    int   send_idle_pct;
    longint cycle_count = 0;

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < NPROC; i++)
            if (sh_active[i] && sh_key[i] == k) return i;
        return -1;
    endfunction

    // take pid p out of the queue of slot d, free the slot when empty
    function automatic void unlink_pid(int d, logic [4:0] p);
        logic at_h;
        logic at_t;
        at_h = (sh_head[d] == p);
        at_t = (sh_tail[d] == p);
        if (at_h && at_t) begin
            sh_active[d] = 1'b0;
        end else if (at_h) begin
            sh_head[d] = sh_next[p];
        end else if (at_t) begin
            sh_tail[d] = sh_prev[p];
        end else begin
            sh_next[sh_prev[p]] = sh_next[p];
            sh_prev[sh_next[p]] = sh_prev[p];
        end
        sh_wait[p] = 1'b0;
    endfunction

    // predicted result of one accepted command, state updated in place
    function automatic aslt_pkg::t_res apply_command(aslt_pkg::t_cmd c);
        aslt_pkg::t_res r;
        int d;
        logic [4:0] p;
        r.status = aslt_pkg::ST_NOTFOUND;
        r.result_proc = '0;
        p = c.proc_id;
        case (c.command)
            aslt_pkg::CMD_INSERT: begin
                if (!sh_wait[p]) begin
                    d = find_slot(c.sem_key);
                    if (d < 0) begin
                        for (int i = 0; i < NPROC; i++)
                            if (!sh_active[i] && d < 0) d = i;
                        if (d < 0) begin
                            r.status = aslt_pkg::ST_NOFREE;
                        end else begin
                            sh_active[d] = 1'b1;
                            sh_key[d] = c.sem_key;
                            sh_head[d] = p;
                            sh_tail[d] = p;
                            sh_prev[p] = p;
                            sh_next[p] = p;
                        end
                    end else begin
                        sh_next[sh_tail[d]] = p;
                        sh_prev[p] = sh_tail[d];
                        sh_next[p] = p;
                        sh_tail[d] = p;
                    end
                    if (d >= 0) begin
                        sh_wait[p] = 1'b1;
                        sh_wkey[p] = c.sem_key;
                        r.status = aslt_pkg::ST_OK;
                    end
                end
            end
            aslt_pkg::CMD_REMOVE, aslt_pkg::CMD_HEAD: begin
                d = find_slot(c.sem_key);
                if (d >= 0) begin
                    r.status = aslt_pkg::ST_OK;
                    r.result_proc = sh_head[d];
                    if (c.command == aslt_pkg::CMD_REMOVE) unlink_pid(d, sh_head[d]);
                end
            end
            default: begin
                if (sh_wait[p]) begin
                    d = find_slot(sh_wkey[p]);
                    if (d >= 0) begin
                        unlink_pid(d, p);
                        r.status = aslt_pkg::ST_OK;
                        r.result_proc = p;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic queue_cmd(logic [1:0] op, logic [31:0] k, logic [4:0] p);
        aslt_pkg::t_cmd c;
        c.command = op;
        c.sem_key = k;
        c.proc_id = p;
        pending_cmds.push_back(c);
    endtask

    // driver: at the falling edge, present the next transaction or idle;
    // start is raised only while the block is idle, so the next rising edge
    // takes it and start drops again at the following falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cmd   <= '0;
        end else if (i_start) begin
            i_start <= 1'b0;
        end else if (!o_busy && pending_cmds.size() != 0 &&
                     $urandom_range(99, 0) >= send_idle_pct) begin
            i_cmd   <= pending_cmds.pop_front();
            i_start <= 1'b1;
        end
    end

    // hand-off bookkeeping at the rising edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_start && !o_busy) begin
            expected_res.push_back(apply_command(i_cmd));
            accepted_count <= accepted_count + 1;
        end
    end

    // monitor: compare every result strobe with the oldest expectation
    always @(posedge i_clk) begin
        aslt_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                report_mismatch("unexpected result count", 1, 0);
            end else begin
                want = expected_res.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.result_proc !== want.result_proc)
                    report_mismatch("result_proc", o_res.result_proc, want.result_proc);
                checked_count++;
                if (want.status == aslt_pkg::ST_OK) ok_count++;
                if (want.status == aslt_pkg::ST_NOFREE) nofree_count++;
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // well-formed random traffic: mostly keys from a small pool, pids that wait
    task automatic random_batch(int n, int nkeys);
        logic [31:0] pool [8];
        int r;
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) pool[i] = $urandom();
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99, 0);
            if (r < 45)
                queue_cmd(aslt_pkg::CMD_INSERT, pool[$urandom_range(nkeys - 1, 0)],
                          5'($urandom_range(31, 0)));
            else if (r < 65)
                queue_cmd(aslt_pkg::CMD_REMOVE, pool[$urandom_range(nkeys - 1, 0)],
                          5'($urandom_range(31, 0)));
            else if (r < 80)
                queue_cmd(aslt_pkg::CMD_OUT, $urandom(), 5'($urandom_range(31, 0)));
            else if (r < 95)
                queue_cmd(aslt_pkg::CMD_HEAD, pool[$urandom_range(nkeys - 1, 0)],
                          5'($urandom_range(31, 0)));
            else
                queue_cmd(2'($urandom_range(3, 0)), $urandom(),
                          5'($urandom_range(31, 0)));
        end
    endtask

    task automatic drain_queue;
        while (pending_cmds.size() != 0 || expected_res.size() != 0 || i_start)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        for (int i = 0; i < NPROC; i++) begin
            sh_active[i] = 1'b0;
            sh_wait[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-table lookups, extremes of key and pid
        queue_cmd(aslt_pkg::CMD_REMOVE, 32'h0, 5'd0);
        queue_cmd(aslt_pkg::CMD_HEAD, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(aslt_pkg::CMD_OUT, 32'h0, 5'd31);
        queue_cmd(aslt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(aslt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 5'd0);
        queue_cmd(aslt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 5'd5);
        queue_cmd(aslt_pkg::CMD_INSERT, 32'h0, 5'd31);          // pid already blocked
        queue_cmd(aslt_pkg::CMD_HEAD, 32'hFFFF_FFFF, 5'd0);
        queue_cmd(aslt_pkg::CMD_OUT, 32'h1234_5678, 5'd0);      // middle of the queue
        queue_cmd(aslt_pkg::CMD_OUT, 32'h0, 5'd5);              // tail
        queue_cmd(aslt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 5'd0);   // last one frees the slot
        queue_cmd(aslt_pkg::CMD_HEAD, 32'hFFFF_FFFF, 5'd0);
        queue_cmd(aslt_pkg::CMD_OUT, 32'h0, 5'd7);              // pid not waiting
        // fill all 32 descriptors with one pid each, which exhausts the pool
        for (int i = 0; i < 32; i++)
            queue_cmd(aslt_pkg::CMD_INSERT, 32'hA000_0000 + i, i[4:0]);
        drain_queue();
        for (int i = 0; i < 4; i++) queue_cmd(aslt_pkg::CMD_OUT, 32'h0, 5'(2 * i));
        queue_cmd(aslt_pkg::CMD_INSERT, 32'h5555_AAAA, 5'd2);   // reuses lowest free slot
        for (int i = 0; i < 32; i++)
            queue_cmd(aslt_pkg::CMD_REMOVE, 32'hA000_0000 + i, 5'd0);
        queue_cmd(aslt_pkg::CMD_REMOVE, 32'h5555_AAAA, 5'd0);
        drain_queue();

        // random phases with different sender idling
        send_idle_pct = 0;
        random_batch(230, 3);
        drain_queue();
        send_idle_pct = 67;
        random_batch(230, 8);
        drain_queue();
        send_idle_pct = 9;
        random_batch(180, 2);
        drain_queue();
        send_idle_pct = 0;
        random_batch(130, 8);
        drain_queue();
        repeat (60) @(posedge i_clk);

        $display("sent %0d commands, checked %0d: %0d ok, %0d pool-exhausted, rest not found",
                 accepted_count, checked_count, ok_count, nofree_count);
        if (error_count == 0 && expected_res.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> semaphore_wait_queue_table_core.f
hw/rtl/aslt_pkg.sv
hw/rtl/semaphore_wait_queue_table_core.sv
tb/sv/testbench.sv
